>>> src/fpe_pkg.sv
// Shared types, constants and codes of the frame-store pixel engine.
package fpe_pkg;

    localparam int FB_WIDTH  = 256;
    localparam int FB_HEIGHT = 256;
    localparam int DEPTH     = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PIX_W     = 16;
    localparam int COORD_W   = 16;
    localparam int LIM_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        FUNC_PLOT  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_LIMIT  = 2'd0,
        REG_Y_LIMIT  = 2'd1,
        REG_BG_COLOR = 2'd2,
        REG_XOR_MODE = 2'd3
    } t_reg_idx;

    typedef enum logic {
        ST_SWEEP = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    // Decoded command: bounds results and store address.
    typedef struct packed {
        logic              plot_ok;
        logic              read_in;
        logic [ADDR_W-1:0] addr;
    } t_dec;

endpackage

>>> src/fpe_ram.sv
// Generic single-port-write, registered-read RAM (read returns old data on a collision).
module fpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fpe_decode.sv
// Command decode: plot and read bounds checks and row-major store address.
module fpe_decode (
    input  logic [fpe_pkg::COORD_W-1:0] i_pos_x,
    input  logic [fpe_pkg::COORD_W-1:0] i_pos_y,
    input  logic [fpe_pkg::LIM_W-1:0]   i_x_limit,
    input  logic [fpe_pkg::LIM_W-1:0]   i_y_limit,
    output fpe_pkg::t_dec               o_dec
);

    logic x_store;
    logic y_store;
    logic x_lim;
    logic y_lim;

    // Negative coordinates fail on the sign bit alone.
    assign x_store = !i_pos_x[fpe_pkg::COORD_W-1]
                     && (i_pos_x < fpe_pkg::COORD_W'(fpe_pkg::FB_WIDTH));
    assign y_store = !i_pos_y[fpe_pkg::COORD_W-1]
                     && (i_pos_y < fpe_pkg::COORD_W'(fpe_pkg::FB_HEIGHT));
    assign x_lim   = i_pos_x < fpe_pkg::COORD_W'(i_x_limit);
    assign y_lim   = i_pos_y < fpe_pkg::COORD_W'(i_y_limit);

    always_comb begin
        o_dec.read_in = x_store && y_store;
        o_dec.plot_ok = x_store && y_store && x_lim && y_lim;
        o_dec.addr    = fpe_pkg::ADDR_W'(fpe_pkg::ADDR_W'(i_pos_y)
                                         * fpe_pkg::ADDR_W'(fpe_pkg::FB_WIDTH))
                        + fpe_pkg::ADDR_W'(i_pos_x);
    end

endmodule

>>> src/framebuffer_pixel_engine_unit.sv
// Top level of the frame-store pixel engine: control, read-modify-write and sweep.
//
// Usage
//   Command channel: drive i_func, i_pos_x, i_pos_y and i_pen with i_start high; the
//   command transfers at a rising edge where i_start is high and o_busy is low.
//   Plot (func 0) writes the pen, or toggles against the background in XOR mode,
//   when the position lies inside both the limits and the store; otherwise it is
//   dropped. Read (func 2) returns o_pixel and o_inside_res on the cycle after its
//   transfer, marked by o_strobe for exactly one cycle. Clear (func 1) and func 3
//   give no result.
//   Throughput: plots and reads transfer one per cycle while o_busy is low. The store
//   is a single registered-read RAM; a plot reads in its transfer cycle and writes in
//   the cycle after; the previous cycle's write is forwarded to the next plot or read.
//   Clear: the store is swept one pixel per cycle over all FB_WIDTH*FB_HEIGHT pixels
//   (65536), with o_busy high throughout.
//   Reset: i_rst_n low sets the registers to their defaults and then runs the same
//   sweep writing zero, so o_busy stays high after reset until that sweep ends.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and
//   are taken at any time, also during a sweep.
//   The result receiver cannot stall: a result not taken in its cycle is lost.
module framebuffer_pixel_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_func,
    input  logic [fpe_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [fpe_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [fpe_pkg::PIX_W-1:0]     i_pen,
    output logic                          o_strobe,
    output logic [fpe_pkg::PIX_W-1:0]     o_pixel,
    output logic                          o_inside_res,
    input  logic                          i_cfg_we,
    input  logic [fpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fpe_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [fpe_pkg::LIM_W-1:0] r_x_limit;
    logic [fpe_pkg::LIM_W-1:0] r_y_limit;
    logic [fpe_pkg::PIX_W-1:0] r_bg_color;
    logic                      r_xor_mode;

    // Control
    fpe_pkg::t_state            r_state;
    fpe_pkg::t_state            n_state;
    logic [fpe_pkg::ADDR_W-1:0] r_sweep_addr;
    logic [fpe_pkg::ADDR_W-1:0] n_sweep_addr;
    logic [fpe_pkg::PIX_W-1:0]  r_fill;
    logic [fpe_pkg::PIX_W-1:0]  n_fill;

    // Second stage: command waiting for its read data
    logic                       r_s2_plot;
    logic                       r_s2_read;
    logic                       r_s2_ok;
    logic [fpe_pkg::ADDR_W-1:0] r_s2_addr;
    logic [fpe_pkg::PIX_W-1:0]  r_s2_pen;
    logic [fpe_pkg::PIX_W-1:0]  r_s2_bg;
    logic                       r_s2_xor;

    // Forwarding of last cycle's plot write
    logic                       r_fw_vld;
    logic [fpe_pkg::ADDR_W-1:0] r_fw_addr;
    logic [fpe_pkg::PIX_W-1:0]  r_fw_data;

    fpe_pkg::t_dec              dec;
    fpe_pkg::t_func             func;
    logic                       accept;
    logic [fpe_pkg::PIX_W-1:0]  ram_rdata;
    logic [fpe_pkg::PIX_W-1:0]  cur_pix;
    logic [fpe_pkg::PIX_W-1:0]  new_pix;
    logic                       plot_we;
    logic                       ram_we;
    logic [fpe_pkg::ADDR_W-1:0] ram_waddr;
    logic [fpe_pkg::PIX_W-1:0]  ram_wdata;

    assign func   = fpe_pkg::t_func'(i_func);
    assign accept = i_start && !o_busy;
    assign o_busy = (r_state == fpe_pkg::ST_SWEEP);

    fpe_decode u_decode (
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_x_limit (r_x_limit),
        .i_y_limit (r_y_limit),
        .o_dec     (dec)
    );

    // Configuration writes: every index of the 2-bit field names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit  <= fpe_pkg::LIM_W'(256);
            r_y_limit  <= fpe_pkg::LIM_W'(256);
            r_bg_color <= '0;
            r_xor_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (fpe_pkg::t_reg_idx'(i_cfg_idx))
                fpe_pkg::REG_X_LIMIT:  r_x_limit  <= i_cfg_data[fpe_pkg::LIM_W-1:0];
                fpe_pkg::REG_Y_LIMIT:  r_y_limit  <= i_cfg_data[fpe_pkg::LIM_W-1:0];
                fpe_pkg::REG_BG_COLOR: r_bg_color <= i_cfg_data[fpe_pkg::PIX_W-1:0];
                fpe_pkg::REG_XOR_MODE: r_xor_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sweep state machine: reset starts a zero fill, a clear command a background fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fpe_pkg::ST_SWEEP;
            r_sweep_addr <= '0;
            r_fill       <= '0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_fill       <= n_fill;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_fill       = r_fill;
        case (r_state)
            fpe_pkg::ST_SWEEP: begin
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (r_sweep_addr == fpe_pkg::ADDR_W'(fpe_pkg::DEPTH - 1)) begin
                    n_state      = fpe_pkg::ST_RUN;
                    n_sweep_addr = '0;
                end
            end
            fpe_pkg::ST_RUN: begin
                // Latch the background so a later register write cannot bend the fill.
                if (accept && func == fpe_pkg::FUNC_CLEAR) begin
                    n_state      = fpe_pkg::ST_SWEEP;
                    n_sweep_addr = '0;
                    n_fill       = r_bg_color;
                end
            end
            default: n_state = fpe_pkg::ST_RUN;
        endcase
    end

    // Advance plots and reads into the second stage; the RAM read is issued meanwhile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_plot <= 1'b0;
            r_s2_read <= 1'b0;
        end else begin
            r_s2_plot <= accept && func == fpe_pkg::FUNC_PLOT;
            r_s2_read <= accept && func == fpe_pkg::FUNC_READ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ok   <= (func == fpe_pkg::FUNC_PLOT) ? dec.plot_ok : dec.read_in;
        r_s2_addr <= dec.addr;
        r_s2_pen  <= i_pen;
        r_s2_bg   <= r_bg_color;
        r_s2_xor  <= r_xor_mode;
    end

    // Forward last cycle's write when it hit the same pixel.
    assign cur_pix = (r_fw_vld && r_fw_addr == r_s2_addr) ? r_fw_data : ram_rdata;
    assign new_pix = (r_s2_xor && cur_pix == r_s2_pen) ? r_s2_bg : r_s2_pen;
    assign plot_we = r_s2_plot && r_s2_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= plot_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= r_s2_addr;
        r_fw_data <= new_pix;
    end

    // The sweep and a plot write never share a cycle: the command after a plot is
    // the clear itself, which leaves the second stage empty.
    always_comb begin
        if (o_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = r_fill;
        end else begin
            ram_we    = plot_we;
            ram_waddr = r_s2_addr;
            ram_wdata = new_pix;
        end
    end

    fpe_ram #(
        .WIDTH (fpe_pkg::PIX_W),
        .DEPTH (fpe_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (dec.addr),
        .o_rdata (ram_rdata)
    );

    // Read result: in the cycle after the transfer, zero when outside the store.
    assign o_strobe     = r_s2_read;
    assign o_inside_res = r_s2_ok;
    assign o_pixel      = r_s2_ok ? cur_pix : '0;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame-store pixel engine: plots, reads, clears and registers.
module tb_top;
    import fpe_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RST_CYCLES    = 3;
    localparam int     NUM_PHASES    = 8;
    localparam int     PHASE_ITEMS   = 240;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     DRAIN_LIMIT   = 200;
    localparam int     MAX_REPORTS   = 10;
    // The timeout covers the reset sweep plus five clear sweeps.
    localparam longint TIMEOUT_NS    = 20_000_000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             in_store;
    } t_read_reply;

    // Shadow copy of the frame store and registers; predicts every read reply.
    class pixel_scoreboard;
        logic [PIX_W-1:0] frame_model [DEPTH];
        logic [LIM_W-1:0] x_lim;
        logic [LIM_W-1:0] y_lim;
        logic [PIX_W-1:0] bg;
        logic             xor_on;
        t_read_reply      replies_due[$];
        int               faults;

        function void reset_state();
            foreach (frame_model[i]) frame_model[i] = '0;
            x_lim   = LIM_W'(FB_WIDTH);
            y_lim   = LIM_W'(FB_HEIGHT);
            bg      = '0;
            xor_on  = 1'b0;
            faults  = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_X_LIMIT:  x_lim  = data[LIM_W-1:0];
                REG_Y_LIMIT:  y_lim  = data[LIM_W-1:0];
                REG_BG_COLOR: bg     = data[PIX_W-1:0];
                REG_XOR_MODE: xor_on = data[0];
                default: ;
            endcase
        endfunction

        function void fault(string msg);
            if (faults < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
            faults++;
        endfunction

        // Apply one accepted command to the shadow store; queue a reply for a read.
        function void note_command(t_func func, logic [COORD_W-1:0] x_raw,
                                   logic [COORD_W-1:0] y_raw, logic [PIX_W-1:0] pen);
            int          x;
            int          y;
            int          xb;
            int          yb;
            int          k;
            t_read_reply reply;
            x  = int'($signed(x_raw));
            y  = int'($signed(y_raw));
            // A limit beyond the store is bounded by the store itself
            xb = (int'(x_lim) < FB_WIDTH)  ? int'(x_lim) : FB_WIDTH;
            yb = (int'(y_lim) < FB_HEIGHT) ? int'(y_lim) : FB_HEIGHT;
            case (func)
                FUNC_PLOT: begin
                    if (x >= 0 && y >= 0 && x < xb && y < yb) begin
                        k = y * FB_WIDTH + x;
                        if (xor_on && frame_model[k] == pen) frame_model[k] = bg;
                        else frame_model[k] = pen;
                    end
                end
                FUNC_CLEAR: begin
                    foreach (frame_model[i]) frame_model[i] = bg;
                end
                FUNC_READ: begin
                    // Reads check the store bounds only, never the limits
                    if (x >= 0 && y >= 0 && x < FB_WIDTH && y < FB_HEIGHT) begin
                        reply.pixel    = frame_model[y * FB_WIDTH + x];
                        reply.in_store = 1'b1;
                    end else begin
                        reply.pixel    = '0;
                        reply.in_store = 1'b0;
                    end
                    replies_due.push_back(reply);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [PIX_W-1:0] pixel, logic in_store);
            t_read_reply want;
            if (replies_due.size() == 0) begin
                fault($sformatf("unexpected reply pixel=%h inside_res=%b", pixel, in_store));
                return;
            end
            want = replies_due.pop_front();
            if (pixel !== want.pixel)
                fault($sformatf("pixel expected %h, got %h", want.pixel, pixel));
            if (in_store !== want.in_store)
                fault($sformatf("inside_res expected %b, got %b", want.in_store, in_store));
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_func;
    logic [COORD_W-1:0]   i_pos_x;
    logic [COORD_W-1:0]   i_pos_y;
    logic [PIX_W-1:0]     i_pen;
    logic                 o_strobe;
    logic [PIX_W-1:0]     o_pixel;
    logic                 o_inside_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    pixel_scoreboard sb;

    framebuffer_pixel_engine_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pen        (i_pen),
        .o_strobe     (o_strobe),
        .o_pixel      (o_pixel),
        .o_inside_res (o_inside_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Replies last one cycle and cannot be held off: take each at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) sb.check_result(o_pixel, o_inside_res);
    end

    // Present a command at the falling edge and hold it until the transfer; return
    // at the next falling edge with start still high, so a burst runs on unbroken.
    task automatic send_cmd(t_func func, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [PIX_W-1:0] pen);
        i_start = 1'b1;
        i_func  = func;
        i_pos_x = x;
        i_pos_y = y;
        i_pen   = pen;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        sb.note_command(func, x, y, pen);
        @(negedge i_clk);
    endtask

    // Drop start for a gap, with junk on the command fields.
    task automatic idle_sender(int cycles);
        i_start = 1'b0;
        repeat (cycles) begin
            i_func  = 2'($urandom);
            i_pos_x = 16'($urandom);
            i_pos_y = 16'($urandom);
            i_pen   = 16'($urandom);
            @(negedge i_clk);
        end
    endtask

    // Plots and clears give no reply, so drain the replies, then wait out any sweep
    // and the trailing store write before the registers are touched.
    task automatic wait_idle();
        i_start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        do @(posedge i_clk); while (o_busy !== 1'b0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // Coordinates lean on a small window so that plots and reads meet often.
    function automatic logic [COORD_W-1:0] pick_coord(int lim);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 15);
            4, 5:       v = $urandom_range(0, 255);
            6:          v = $urandom_range((lim > 1) ? lim - 2 : 0, lim + 1);
            7:          v = $urandom_range(256, 300);
            8:          v = -int'($urandom_range(1, 4));
            default:    v = $urandom();
        endcase
        return COORD_W'(v);
    endfunction

    // Repeat colours often so that the XOR toggle is hit both ways.
    function automatic logic [PIX_W-1:0] pick_pen();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return sb.bg;
            3:       return 16'hF800;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 9'd1;
            2:       return 9'd8;
            3:       return 9'd16;
            4:       return 9'd255;
            5:       return 9'd256;
            6:       return 9'd511;
            default: return LIM_W'($urandom());
        endcase
    endfunction

    initial begin
        logic [CFG_DAT_W-1:0] d;
        logic [COORD_W-1:0]   lx;
        logic [COORD_W-1:0]   ly;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        int                   burst_left;
        int                   clear_at;
        int                   r;
        int                   n;
        t_func                f;

        sb = new();
        sb.reset_state();
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_func     = FUNC_PLOT;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_pen      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_X_LIMIT;
        i_cfg_data = '0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        // Reset kicks off a zeroing sweep; hold until it ends
        wait_idle();

        // Directed: store corners, outside reads, drops and the unused code
        send_cmd(FUNC_READ,  16'd0,     16'd0,     16'h0000);
        send_cmd(FUNC_READ,  16'd255,   16'd255,   16'h0000);
        send_cmd(FUNC_READ,  16'hFFFF,  16'd0,     16'h0000);
        send_cmd(FUNC_READ,  16'd0,     16'd256,   16'h0000);
        send_cmd(FUNC_READ,  16'h8000,  16'h7FFF,  16'h0000);
        send_cmd(FUNC_PLOT,  16'd0,     16'd0,     16'hFFFF);
        send_cmd(FUNC_READ,  16'd0,     16'd0,     16'h0000);
        send_cmd(FUNC_PLOT,  16'd255,   16'd255,   16'h1234);
        send_cmd(FUNC_READ,  16'd255,   16'd255,   16'h0000);
        send_cmd(FUNC_PLOT,  16'hFFFF,  16'd5,     16'hAAAA);
        // x just past the store must not wrap into the next row
        send_cmd(FUNC_PLOT,  16'd256,   16'd0,     16'h5555);
        send_cmd(FUNC_READ,  16'd0,     16'd1,     16'h0000);
        send_cmd(FUNC_NONE,  16'd0,     16'd0,     16'h0000);
        send_cmd(FUNC_READ,  16'd0,     16'd0,     16'h0000);

        // Zero limit: every plot dropped; upper data bits are junk
        wait_idle();
        cfg_write(REG_X_LIMIT, 16'hFE00);
        send_cmd(FUNC_PLOT,  16'd0,     16'd0,     16'h0000);
        send_cmd(FUNC_READ,  16'd0,     16'd0,     16'h0000);

        // Limits beyond the store, XOR toggle, then a clear to the background
        wait_idle();
        cfg_write(REG_X_LIMIT,  16'h01FF);
        cfg_write(REG_Y_LIMIT,  16'd300);
        cfg_write(REG_BG_COLOR, 16'hABCD);
        cfg_write(REG_XOR_MODE, 16'hFFFF);
        send_cmd(FUNC_PLOT,  16'd255,   16'd255,   16'h1234);
        send_cmd(FUNC_READ,  16'd255,   16'd255,   16'h0000);
        send_cmd(FUNC_PLOT,  16'd255,   16'd0,     16'h7777);
        send_cmd(FUNC_READ,  16'd255,   16'd0,     16'h0000);
        // Row 300 is outside both the limit and the store; row 44 is where it would wrap
        send_cmd(FUNC_PLOT,  16'd5,     16'd300,   16'h1111);
        send_cmd(FUNC_READ,  16'd5,     16'd44,    16'h0000);
        send_cmd(FUNC_CLEAR, 16'd0,     16'd0,     16'h0000);
        send_cmd(FUNC_READ,  16'd3,     16'd3,     16'h0000);

        wait_idle();
        cfg_write(REG_Y_LIMIT, 16'd0);
        send_cmd(FUNC_PLOT,  16'd1,     16'd1,     16'h0000);
        send_cmd(FUNC_READ,  16'd1,     16'd1,     16'h0000);

        // Random phases: fresh registers each phase, a clear in every other one
        lx = '0;
        ly = '0;
        burst_left = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            d = CFG_DAT_W'($urandom());
            d[LIM_W-1:0] = pick_limit();
            cfg_write(REG_X_LIMIT, d);
            d = CFG_DAT_W'($urandom());
            d[LIM_W-1:0] = pick_limit();
            cfg_write(REG_Y_LIMIT, d);
            case ($urandom_range(0, 3))
                0:       d = '0;
                1:       d = '1;
                default: d = CFG_DAT_W'($urandom());
            endcase
            cfg_write(REG_BG_COLOR, d);
            cfg_write(REG_XOR_MODE, CFG_DAT_W'($urandom()));
            clear_at = (p % 2 == 1) ? int'($urandom_range(0, PHASE_ITEMS - 1)) : -1;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (burst_left == 0) begin
                    idle_sender($urandom_range(1, 12));
                    // Now and then a long burst with no gaps at all
                    burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 30);
                end
                burst_left--;
                r = $urandom_range(0, 99);
                if (i == clear_at)  f = FUNC_CLEAR;
                else if (r < 55)    f = FUNC_PLOT;
                else if (r < 95)    f = FUNC_READ;
                else                f = FUNC_NONE;
                // Revisit the last plotted pixel to hit the write forwarding
                if ($urandom_range(0, 9) < 3) begin
                    cx = lx;
                    cy = ly;
                end else begin
                    cx = pick_coord(int'(sb.x_lim));
                    cy = pick_coord(int'(sb.y_lim));
                end
                if (f == FUNC_PLOT) begin
                    lx = cx;
                    ly = cy;
                end
                send_cmd(f, cx, cy, pick_pen());
            end
        end

        // Drain the last replies, then watch a little longer for strays
        i_start = 1'b0;
        n = 0;
        while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        repeat (2 * SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) sb.fault($sformatf("%0d replies never arrived", sb.pending()));

        if (sb.faults == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total", sb.faults);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/fpe_pkg.sv
src/fpe_ram.sv
src/fpe_decode.sv
src/framebuffer_pixel_engine_unit.sv
tb/tb_top.sv
